FILE: rtl/rpfp_pkg.sv
package rpfp_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int HEADER_LEN          = 4;
    localparam int MIN_FRAME_BYTES     = 23;
    localparam int REPORT_FIRST        = 8;
    localparam int REPORT_COUNT        = 9;
    localparam int REPORT_IDX_W        = 4;
    localparam int SCORE_W             = 14;
    localparam int SCORE_SUM_W         = 15;

    localparam logic [7:0] TRAILER_0 = 8'hF8;
    localparam logic [7:0] TRAILER_1 = 8'hF7;
    localparam logic [7:0] TRAILER_2 = 8'hF6;
    localparam logic [7:0] TRAILER_3 = 8'hF5;

    localparam logic [SCORE_SUM_W-1:0] SCORE_MAX       = 15'd10000;
    localparam logic [6:0]             STATIC_WEIGHT   = 7'd65;
    localparam logic [6:0]             MOVING_WEIGHT   = 7'd35;

    localparam logic [7:0] STATE_MOVING = 8'd1;
    localparam logic [7:0] STATE_STATIC = 8'd2;
    localparam logic [7:0] STATE_BOTH   = 8'd3;

    // frame fields as captured, before decoding
    typedef struct packed {
        logic [7:0]  target_state;
        logic [15:0] moving_distance;
        logic [7:0]  moving_energy;
        logic [15:0] static_distance;
        logic [7:0]  static_energy;
        logic [15:0] detection_distance;
    } raw_report_t;

    typedef struct packed {
        logic               has_target;
        logic               is_moving;
        logic               is_static;
        logic [15:0]        moving_distance_cm;
        logic [7:0]         moving_energy;
        logic [15:0]        static_distance_cm;
        logic [7:0]         static_energy;
        logic [15:0]        detection_distance_cm;
        logic [SCORE_W-1:0] presence_score_centi;
    } report_t;

    function automatic logic [7:0] header_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hF4;
            2'd1:    b = 8'hF3;
            2'd2:    b = 8'hF2;
            2'd3:    b = 8'hF1;
            default: b = 8'hF4;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/rpfp_frame_sync.sv
module rpfp_frame_sync
    import rpfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    output logic        frame_done,
    output raw_report_t raw_report
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       report_bytes_reg [REPORT_COUNT];
    logic [7:0]       recent_reg [3];
    logic             done;
    logic             in_report;
    logic [REPORT_IDX_W-1:0] report_idx;

    assign in_report  = (pos_reg >= POS_W'(REPORT_FIRST)) &&
                        (pos_reg < POS_W'(REPORT_FIRST + REPORT_COUNT));
    assign report_idx = REPORT_IDX_W'(pos_reg - POS_W'(REPORT_FIRST));

    always_comb begin
        done     = 1'b0;
        pos_next = pos_reg + 1'b1;
        if (pos_reg < POS_W'(HEADER_LEN)) begin
            // wrong header byte is dropped, hunt restarts
            if (rx_byte != header_byte(pos_reg[1:0])) begin
                pos_next = '0;
            end
        end else begin
            done = (pos_reg >= POS_W'(MIN_FRAME_BYTES - 1)) &&
                   (recent_reg[2] == TRAILER_0) && (recent_reg[1] == TRAILER_1) &&
                   (recent_reg[0] == TRAILER_2) && (rx_byte == TRAILER_3);
            if (done || pos_reg == POS_W'(MAX_FRAME_BYTES - 1)) begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pos_reg >= POS_W'(HEADER_LEN)) begin
            if (in_report) begin
                report_bytes_reg[report_idx] <= rx_byte;
            end
            recent_reg[2] <= recent_reg[1];
            recent_reg[1] <= recent_reg[0];
            recent_reg[0] <= rx_byte;
        end
    end

    assign frame_done = accept && done;

    assign raw_report.target_state       = report_bytes_reg[0];
    assign raw_report.moving_distance    = {report_bytes_reg[2], report_bytes_reg[1]};
    assign raw_report.moving_energy      = report_bytes_reg[3];
    assign raw_report.static_distance    = {report_bytes_reg[5], report_bytes_reg[4]};
    assign raw_report.static_energy      = report_bytes_reg[6];
    assign raw_report.detection_distance = {report_bytes_reg[8], report_bytes_reg[7]};

endmodule

FILE: rtl/rpfp_report_out.sv
module rpfp_report_out
    import rpfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  raw_report_t raw_report,
    output logic        full,
    output logic        m_valid,
    input  logic        m_ready,
    output report_t     report
);

    report_t                report_in;
    logic [SCORE_SUM_W-1:0] score_sum;
    logic                   has;

    report_t main_reg;
    report_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;

    always_comb begin
        has       = raw_report.target_state != 8'd0;
        score_sum = SCORE_SUM_W'(STATIC_WEIGHT) * SCORE_SUM_W'(raw_report.static_energy) +
                    SCORE_SUM_W'(MOVING_WEIGHT) * SCORE_SUM_W'(raw_report.moving_energy);

        report_in.has_target = has;
        report_in.is_moving  = (raw_report.target_state == STATE_MOVING) ||
                               (raw_report.target_state == STATE_BOTH);
        report_in.is_static  = (raw_report.target_state == STATE_STATIC) ||
                               (raw_report.target_state == STATE_BOTH);
        report_in.moving_distance_cm    = raw_report.moving_distance;
        report_in.moving_energy         = raw_report.moving_energy;
        report_in.static_distance_cm    = raw_report.static_distance;
        report_in.static_energy         = raw_report.static_energy;
        report_in.detection_distance_cm = raw_report.detection_distance;
        if (!has) begin
            report_in.presence_score_centi = '0;
        end else if (score_sum > SCORE_MAX) begin
            report_in.presence_score_centi = SCORE_W'(SCORE_MAX);
        end else begin
            report_in.presence_score_centi = SCORE_W'(score_sum);
        end
    end

    // main register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= load;
            end else begin
                main_valid_reg <= load;
            end
        end else if (load) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (load) begin
                    skid_reg <= report_in;
                end
            end else if (load) begin
                main_reg <= report_in;
            end
        end else if (load) begin
            skid_reg <= report_in;
        end
    end

    assign full    = skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign report  = main_reg;

endmodule

FILE: rtl/radar_presence_frame_parser.sv
// channel   ports                            direction  carries
// input     s_valid s_ready s_rx_byte        in         one serial byte per transaction
// result    m_valid m_ready m_* report       out        one report per completed frame
//
// one byte is taken every cycle while s_ready is high; the report of a frame is
// registered into the report register or its skid entry as its trailer is taken
// s_ready falls only while the report register and its skid entry both hold
// unread reports, so a stalled result side blocks the input after two reports
// aresetn is synchronous and active low; it returns the parser to header hunt
// and empties the result register and its skid entry
module radar_presence_frame_parser
    import rpfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_has_target,
    output logic               m_is_moving,
    output logic               m_is_static,
    output logic [15:0]        m_moving_distance_cm,
    output logic [7:0]         m_moving_energy,
    output logic [15:0]        m_static_distance_cm,
    output logic [7:0]         m_static_energy,
    output logic [15:0]        m_detection_distance_cm,
    output logic [SCORE_W-1:0] m_presence_score_centi
);

    logic        accept;
    logic        frame_done;
    logic        full;
    raw_report_t raw_report;
    report_t     report;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    rpfp_frame_sync #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_sync (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_rx_byte),
        .frame_done (frame_done),
        .raw_report (raw_report)
    );

    rpfp_report_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (frame_done),
        .raw_report (raw_report),
        .full       (full),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .report     (report)
    );

    assign m_has_target            = report.has_target;
    assign m_is_moving             = report.is_moving;
    assign m_is_static             = report.is_static;
    assign m_moving_distance_cm    = report.moving_distance_cm;
    assign m_moving_energy         = report.moving_energy;
    assign m_static_distance_cm    = report.static_distance_cm;
    assign m_static_energy         = report.static_energy;
    assign m_detection_distance_cm = report.detection_distance_cm;
    assign m_presence_score_centi  = report.presence_score_centi;

endmodule

FILE: sim/presence_report_checker.sv
module presence_report_checker
    import rpfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_has_target,
    input  logic               m_is_moving,
    input  logic               m_is_static,
    input  logic [15:0]        m_moving_distance_cm,
    input  logic [7:0]         m_moving_energy,
    input  logic [15:0]        m_static_distance_cm,
    input  logic [7:0]         m_static_energy,
    input  logic [15:0]        m_detection_distance_cm,
    input  logic [SCORE_W-1:0] m_presence_score_centi,
    output int                 mismatches,
    output int                 reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SYNC_WORD = 32'hF4F3F2F1;

    report_t    awaited_reports [$];
    int         frame_pos;
    logic [7:0] captured [REPORT_COUNT];
    logic [7:0] last_three [3];
    int         error_count = 0;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        logic [7:0] b;
        logic       closes;
        int         sum;
        report_t    want;
        if (!aresetn) begin
            frame_pos = 0;
            foreach (last_three[i]) last_three[i] = '0;
            foreach (captured[i]) captured[i] = '0;
            awaited_reports.delete();
        end else begin
            if (s_valid && s_ready) begin
                b = s_rx_byte;
                if (frame_pos < HEADER_LEN) begin
                    // a wrong header byte is dropped, never retried as a new start
                    if (b == SYNC_WORD[31 - 8*frame_pos -: 8]) frame_pos++;
                    else frame_pos = 0;
                end else begin
                    if (frame_pos >= REPORT_FIRST && frame_pos < REPORT_FIRST + REPORT_COUNT)
                        captured[frame_pos - REPORT_FIRST] = b;
                    closes = (frame_pos + 1 >= MIN_FRAME_BYTES) &&
                             last_three[2] == TRAILER_0 && last_three[1] == TRAILER_1 &&
                             last_three[0] == TRAILER_2 && b == TRAILER_3;
                    last_three[2] = last_three[1];
                    last_three[1] = last_three[0];
                    last_three[0] = b;
                    if (closes) begin
                        want.has_target = captured[0] != 8'd0;
                        want.is_moving  = captured[0] == STATE_MOVING ||
                                          captured[0] == STATE_BOTH;
                        want.is_static  = captured[0] == STATE_STATIC ||
                                          captured[0] == STATE_BOTH;
                        want.moving_distance_cm    = {captured[2], captured[1]};
                        want.moving_energy         = captured[3];
                        want.static_distance_cm    = {captured[5], captured[4]};
                        want.static_energy         = captured[6];
                        want.detection_distance_cm = {captured[8], captured[7]};
                        sum = want.has_target ? 65 * captured[6] + 35 * captured[3] : 0;
                        if (sum > SCORE_MAX) sum = SCORE_MAX;
                        want.presence_score_centi = sum[SCORE_W-1:0];
                        awaited_reports.push_back(want);
                        frame_pos = 0;
                    end else if (frame_pos + 1 >= MAX_FRAME_BYTES) begin
                        frame_pos = 0;
                    end else begin
                        frame_pos++;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (awaited_reports.size() == 0) begin
                    $error("report transaction with none expected");
                    error_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("has_target", want.has_target, m_has_target);
                    check_field("is_moving", want.is_moving, m_is_moving);
                    check_field("is_static", want.is_static, m_is_static);
                    check_field("moving_distance_cm", want.moving_distance_cm,
                                m_moving_distance_cm);
                    check_field("moving_energy", want.moving_energy, m_moving_energy);
                    check_field("static_distance_cm", want.static_distance_cm,
                                m_static_distance_cm);
                    check_field("static_energy", want.static_energy, m_static_energy);
                    check_field("detection_distance_cm", want.detection_distance_cm,
                                m_detection_distance_cm);
                    check_field("presence_score_centi", want.presence_score_centi,
                                m_presence_score_centi);
                end
            end
        end
        mismatches  <= error_count;
        reports_due <= awaited_reports.size();
    end

endmodule

FILE: sim/testbench.sv
module testbench;
    import rpfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SYNC_WORD   = 32'hF4F3F2F1;
    localparam int          BYTE_TARGET = 1650;
    localparam int          LONG_STALL  = 400;
    localparam int          IDLE_LIMIT  = 5000;
    localparam int          SETTLE      = 20;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_has_target;
    logic               m_is_moving;
    logic               m_is_static;
    logic [15:0]        m_moving_distance_cm;
    logic [7:0]         m_moving_energy;
    logic [15:0]        m_static_distance_cm;
    logic [7:0]         m_static_energy;
    logic [15:0]        m_detection_distance_cm;
    logic [SCORE_W-1:0] m_presence_score_centi;

    int         mismatches;
    int         reports_due;
    int         burst_left     = 0;
    int         bytes_sent     = 0;
    int         stall_requests = 0;
    int         stalls_served  = 0;
    int         idle_cycles    = 0;
    logic [7:0] planted [$];

    radar_presence_frame_parser i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_rx_byte              (s_rx_byte),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_has_target           (m_has_target),
        .m_is_moving            (m_is_moving),
        .m_is_static            (m_is_static),
        .m_moving_distance_cm   (m_moving_distance_cm),
        .m_moving_energy        (m_moving_energy),
        .m_static_distance_cm   (m_static_distance_cm),
        .m_static_energy        (m_static_energy),
        .m_detection_distance_cm(m_detection_distance_cm),
        .m_presence_score_centi (m_presence_score_centi)
    );

    presence_report_checker i_checker (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_rx_byte              (s_rx_byte),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_has_target           (m_has_target),
        .m_is_moving            (m_is_moving),
        .m_is_static            (m_is_static),
        .m_moving_distance_cm   (m_moving_distance_cm),
        .m_moving_energy        (m_moving_energy),
        .m_static_distance_cm   (m_static_distance_cm),
        .m_static_energy        (m_static_energy),
        .m_detection_distance_cm(m_detection_distance_cm),
        .m_presence_score_centi (m_presence_score_centi),
        .mismatches             (mismatches),
        .reports_due            (reports_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // bursts of random length, random gaps or none between them; valid held across a burst
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 500)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender stops and waits until every predicted report has been taken
    task automatic drain_reports();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_due != 0);
    endtask

    // header, four free bytes, report fields, planted bytes, random fill, trailer
    task automatic send_frame(input logic [7:0] state, input logic [15:0] mdist,
                              input logic [7:0] men, input logic [15:0] sdist,
                              input logic [7:0] sen, input logic [15:0] ddist,
                              input int len);
        logic [7:0] f [$];
        for (int i = 0; i < HEADER_LEN; i++) f.push_back(SYNC_WORD[31 - 8*i -: 8]);
        repeat (4) f.push_back(8'($urandom_range(0, 255)));
        f.push_back(state);
        f.push_back(mdist[7:0]);
        f.push_back(mdist[15:8]);
        f.push_back(men);
        f.push_back(sdist[7:0]);
        f.push_back(sdist[15:8]);
        f.push_back(sen);
        f.push_back(ddist[7:0]);
        f.push_back(ddist[15:8]);
        while (planted.size() > 0) f.push_back(planted.pop_front());
        while (f.size() < len - 4) f.push_back(8'($urandom_range(0, 255)));
        f.push_back(TRAILER_0);
        f.push_back(TRAILER_1);
        f.push_back(TRAILER_2);
        f.push_back(TRAILER_3);
        foreach (f[i]) send_byte(f[i]);
        bytes_sent += f.size();
    endtask

    task automatic send_random_frame(input int len);
        logic [7:0] state;
        logic [7:0] men;
        logic [7:0] sen;
        state = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 3))
                                           : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) begin
            men = 8'($urandom_range(0, 255));
            sen = 8'($urandom_range(0, 255));
        end else begin
            // around the saturation threshold
            men = 8'($urandom_range(80, 120));
            sen = 8'($urandom_range(80, 120));
        end
        send_frame(state, 16'($urandom_range(0, 65535)), men,
                   16'($urandom_range(0, 65535)), sen,
                   16'($urandom_range(0, 65535)), len);
    endtask

    initial begin : stimulus
        int choice;
        int k;
        logic [7:0] wrong;
        bit stalled_once;
        bit drained_once;
        stalled_once = 0;
        drained_once = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // hunting: bytes that are not a header start
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'hF5);
        // repeated start byte is dropped, not taken as a fresh header
        send_byte(8'hF4);
        send_byte(8'hF4);
        send_byte(8'hF3);
        send_byte(8'hF4);
        send_byte(8'hF3);
        send_byte(8'hF2);
        send_byte(8'h00);
        send_frame(8'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 23);
        send_frame(STATE_MOVING, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 23);
        send_frame(STATE_STATIC, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 24);
        send_frame(STATE_BOTH, 16'h1234, 8'd100, 16'h5678, 8'd100, 16'h9ABC, 23);
        send_frame(STATE_BOTH, 16'h00FF, 8'd100, 16'hFF00, 8'd99, 16'h8001, 23);
        send_frame(8'hFF, 16'h0001, 8'd1, 16'h8000, 8'd0, 16'h7FFF, 25);
        send_frame(8'd4, 16'hA5A5, 8'd0, 16'h5A5A, 8'd1, 16'h0100, 23);
        // trailer inside the report fields is too early to close the frame
        send_frame(STATE_MOVING, 16'h1111, 8'd7, 16'hF822, TRAILER_1, 16'hF5F6, 23);
        // trailer ending one byte short of the minimum length
        planted = {8'h3C, TRAILER_0, TRAILER_1, TRAILER_2, TRAILER_3};
        send_frame(STATE_STATIC, 16'h0203, 8'd9, 16'h0405, 8'd33, 16'h0607, 27);
        // trailer on the last allowed byte, then one byte too long
        send_frame(STATE_BOTH, 16'hFFFE, 8'd250, 16'h0002, 8'd3, 16'hC000, 64);
        send_frame(STATE_MOVING, 16'h0101, 8'd2, 16'h0202, 8'd4, 16'h0303, 65);
        drain_reports();

        while (bytes_sent < BYTE_TARGET) begin
            if (!stalled_once && bytes_sent > 500) begin
                stalled_once = 1;
                stall_requests++;
                burst_left = 300;
                repeat (6) send_random_frame(23);
            end else if (!drained_once && bytes_sent > 1000) begin
                drained_once = 1;
                drain_reports();
            end
            choice = $urandom_range(0, 99);
            if (choice < 72) begin
                send_random_frame(($urandom_range(0, 9) == 0) ? $urandom_range(31, 64)
                                                              : $urandom_range(23, 30));
            end else if (choice < 80) begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end else if (choice < 88) begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) send_byte(SYNC_WORD[31 - 8*i -: 8]);
                wrong = 8'($urandom_range(0, 255));
                if (wrong == SYNC_WORD[31 - 8*k -: 8]) wrong = 8'hF4;
                send_byte(wrong);
            end else if (choice < 93) begin
                // no trailer: position wraps and the tail is hunted through
                for (int i = 0; i < HEADER_LEN; i++) send_byte(SYNC_WORD[31 - 8*i -: 8]);
                k = $urandom_range(56, 70);
                repeat (k) send_byte(8'($urandom_range(0, 255)));
                bytes_sent += k + HEADER_LEN;
            end else begin
                planted.delete();
                k = $urandom_range(0, 4);
                repeat (k) planted.push_back(8'($urandom_range(0, 255)));
                planted.push_back(TRAILER_0);
                planted.push_back(TRAILER_1);
                planted.push_back(TRAILER_2);
                planted.push_back(TRAILER_3);
                send_random_frame($urandom_range(28, 40));
            end
        end

        drain_reports();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : result_sink
        int mode;
        int mode_left;
        int phase;
        mode_left = 0;
        phase     = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (stall_requests != stalls_served) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                stalls_served++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            phase++;
            case (mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 9) < 7);
                end
                2: begin
                    m_ready <= ($urandom_range(0, 9) < 3);
                end
                default: begin
                    m_ready <= (phase % 4 == 0);
                end
            endcase
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
